// File: src/leb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_pkg
// Shared types and constants for the padded LEB128 encoder.
// ----------------------------------------------------------------------------
package leb_pkg;

    localparam int VALUE_W = 64;
    localparam int DIGIT_W = 7;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 5;

    // Largest minimum length honored; larger requests saturate to it.
    localparam int MAX_PAD = 16;
    localparam logic [CNT_W-1:0] PAD_SAT =
        (MAX_PAD > (2**CNT_W - 1)) ? {CNT_W{1'b1}} : CNT_W'(MAX_PAD);

    localparam logic [DIGIT_W-1:0] PAD_POS = 7'h00;
    localparam logic [DIGIT_W-1:0] PAD_NEG = 7'h7F;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DATA = 3'b010,
        ST_PAD  = 3'b100
    } t_state;

    // Digit shifter -> sequencer
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;     // low group of what is left
        logic               rest_zero; // what is left after this group is 0
        logic               rest_ones; // what is left after this group is all ones
        logic               rest_neg;  // signed and negative after this group
    } t_digit;

    // Sequencer -> output register
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [CNT_W-1:0]  total;
    } t_emit;

endpackage

// File: src/leb_digit_sr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_digit_sr
// Value shift register: loads a value and moves it down one 7-bit group per
// shift, filling with the sign bit for signed values.
// ----------------------------------------------------------------------------
module leb_digit_sr (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic [leb_pkg::VALUE_W-1:0]  i_value,
    input  logic                         i_is_signed,
    input  logic                         i_shift,
    output leb_pkg::t_digit              o_digit
);

    logic [leb_pkg::VALUE_W-1:0] r_rem;
    logic                        r_sgn;
    logic [leb_pkg::VALUE_W-1:0] n_rem;
    logic                        w_fill;

    assign w_fill = r_sgn & r_rem[leb_pkg::VALUE_W-1];
    assign n_rem  = {{leb_pkg::DIGIT_W{w_fill}},
                     r_rem[leb_pkg::VALUE_W-1:leb_pkg::DIGIT_W]};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= i_value;
            r_sgn <= i_is_signed;
        end else if (i_shift) begin
            r_rem <= n_rem;
        end
    end

    assign o_digit.digit     = r_rem[leb_pkg::DIGIT_W-1:0];
    assign o_digit.rest_zero = (n_rem == '0);
    assign o_digit.rest_ones = (n_rem == '1);
    assign o_digit.rest_neg  = w_fill;

endmodule

// File: src/leb_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_seq
// Byte sequencer: forms one encoded byte per step, decides on the end of the
// data groups and runs the padding tail.
// ----------------------------------------------------------------------------
module leb_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_is_signed,
    input  logic [leb_pkg::CNT_W-1:0]   i_pad_to,
    input  logic                        i_step,
    input  leb_pkg::t_digit             i_digit,
    output logic                        o_idle,
    output logic                        o_shift,
    output leb_pkg::t_emit              o_emit
);

    leb_pkg::t_state                 r_state, n_state;
    logic [leb_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [leb_pkg::CNT_W-1:0]       r_pad, n_pad;
    logic                            r_sgn, n_sgn;
    logic [leb_pkg::DIGIT_W-1:0]     r_pv, n_pv;
    logic [leb_pkg::CNT_W-1:0]       w_cnt_inc;
    logic                            w_more;
    logic                            w_pad_more;

    assign w_cnt_inc  = r_cnt + 1'b1;
    assign w_pad_more = (w_cnt_inc < r_pad);

    // signed: stop when the rest is pure sign and bit 6 matches it
    always_comb begin
        if (r_sgn)
            w_more = !((i_digit.rest_zero && !i_digit.digit[6]) ||
                       (i_digit.rest_ones &&  i_digit.digit[6]));
        else
            w_more = !i_digit.rest_zero;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pad   = r_pad;
        n_sgn   = r_sgn;
        n_pv    = r_pv;
        o_emit  = '0;
        o_shift = 1'b0;
        unique case (r_state)
            leb_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = leb_pkg::ST_DATA;
                    n_cnt   = '0;
                    n_sgn   = i_is_signed;
                    n_pad   = (i_pad_to > leb_pkg::PAD_SAT) ? leb_pkg::PAD_SAT : i_pad_to;
                end
            end
            leb_pkg::ST_DATA: begin
                if (i_step) begin
                    o_shift      = 1'b1;
                    o_emit.valid = 1'b1;
                    o_emit.data  = {w_more | w_pad_more, i_digit.digit};
                    n_cnt        = w_cnt_inc;
                    if (!w_more) begin
                        if (w_pad_more) begin
                            n_state = leb_pkg::ST_PAD;
                            n_pv    = i_digit.rest_neg ? leb_pkg::PAD_NEG : leb_pkg::PAD_POS;
                        end else begin
                            n_state      = leb_pkg::ST_IDLE;
                            o_emit.last  = 1'b1;
                            o_emit.total = w_cnt_inc;
                        end
                    end
                end
            end
            leb_pkg::ST_PAD: begin
                if (i_step) begin
                    o_emit.valid = 1'b1;
                    o_emit.data  = {w_pad_more, r_pv};
                    n_cnt        = w_cnt_inc;
                    if (!w_pad_more) begin
                        n_state      = leb_pkg::ST_IDLE;
                        o_emit.last  = 1'b1;
                        o_emit.total = w_cnt_inc;
                    end
                end
            end
            default: n_state = leb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= leb_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pad <= n_pad;
        r_sgn <= n_sgn;
        r_pv  <= n_pv;
    end

    assign o_idle = (r_state == leb_pkg::ST_IDLE);

endmodule

// File: src/leb128_padded_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb128_padded_encoder
// LEB128 encoder (unsigned or signed) with a minimum output length.
// ----------------------------------------------------------------------------
//  channel | dir | transfer                     | payload
//  s_*     | in  | one value to encode          | tdata: value[63:0], pad_to[68:64]
//          |     |                              | tuser: is_signed
//  m_*     | out | one encoded byte             | tdata: out_byte[7:0], total_bytes[12:8]
//          |     |                              | tlast: final byte of the value
//
//  Sequencing: one input transfer, then one output byte per cycle from the 7-bit
//    digit shifter unless the output stalls, N bytes with N = max(natural length
//    1..10, min(pad_to,16)). The next input is taken once the sequencer has
//    formed the last byte of the current one.
//  Reset: i_rst_n synchronous, active low; clears sequencer state and the
//    output valid flag.
//  Stalls: i_m_tready low while the output register holds a byte holds that
//    register and freezes the shifter and sequencer; no byte is dropped.
// ----------------------------------------------------------------------------
module leb128_padded_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // [63:0] value, [68:64] pad_to, rest zero
    input  logic        i_s_tuser,   // [0] is_signed
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] out_byte, [12:8] total_bytes, rest zero
    output logic        o_m_tlast
);

    logic                             w_accept;
    logic                             w_out_free;
    logic                             w_idle;
    logic                             w_shift;
    leb_pkg::t_digit                  w_digit;
    leb_pkg::t_emit                   w_emit;

    logic                             r_out_valid;
    logic [leb_pkg::BYTE_W-1:0]       r_out_byte;
    logic [leb_pkg::CNT_W-1:0]        r_out_total;
    logic                             r_out_last;

    assign o_s_tready = w_idle;
    assign w_accept   = i_s_tvalid & w_idle;
    // sequencer may step when the output register is empty or draining
    assign w_out_free = !r_out_valid | i_m_tready;

    leb_digit_sr u_sr (
        .i_clk       (i_clk),
        .i_load      (w_accept),
        .i_value     (i_s_tdata[leb_pkg::VALUE_W-1:0]),
        .i_is_signed (i_s_tuser),
        .i_shift     (w_shift),
        .o_digit     (w_digit)
    );

    leb_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept),
        .i_is_signed (i_s_tuser),
        .i_pad_to    (i_s_tdata[68:64]),
        .i_step      (w_out_free),
        .i_digit     (w_digit),
        .o_idle      (w_idle),
        .o_shift     (w_shift),
        .o_emit      (w_emit)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_emit.valid) begin
            r_out_byte  <= w_emit.data;
            r_out_total <= w_emit.total;
            r_out_last  <= w_emit.last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_total, r_out_byte};
    assign o_m_tlast  = r_out_last;

endmodule

// File: src/leb_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_chk
// Port-level checker for the padded LEB128 encoder, bound to the top level.
// ----------------------------------------------------------------------------
module leb_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        o_s_tready,
    input  logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] o_m_tdata,
    input  logic        o_m_tlast
);

    // final byte has continuation clear and a nonzero count
    a_last_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (!o_m_tdata[7] && (o_m_tdata[12:8] != 5'd0)))
        else $error("final byte malformed");

    // other bytes carry continuation and no count
    a_mid_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> (o_m_tdata[7] && (o_m_tdata[12:8] == 5'd0)))
        else $error("continuation byte malformed");

    // one value at a time: input closes right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input ready after transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("output changed under stall");

endmodule

bind leb128_padded_encoder leb_chk u_leb_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
